[sv/lip_pkg.sv]
// ----------------------------------------------------------------------------
// lip_pkg: shared types and constants for lattice inversion pairing
// Transaction payloads, cell chain control and token types, register indexes.
// ----------------------------------------------------------------------------
package lip_pkg;

  // Default list capacity
  localparam int MAX_VECTORS_DEF = 64;

  // Field widths
  localparam int NUM_AXES  = 3;
  localparam int COMP_W    = 8;
  localparam int PERIOD_W  = 8;
  localparam int OUT_IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_X = 2'd0,
    REG_PERIOD_Y = 2'd1,
    REG_PERIOD_Z = 2'd2
  } cfg_reg_t;

  // Input transaction
  typedef struct packed {
    logic signed [COMP_W-1:0] trans_x;
    logic signed [COMP_W-1:0] trans_y;
    logic signed [COMP_W-1:0] trans_z;
    logic                     end_of_list;
  } item_t;

  // Output transaction
  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic [OUT_IDX_W-1:0] partner_index;
    logic                 partner_found;
    logic                 last_result;
  } result_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                                   load;
    logic                                   step;
    logic                                   shift;
    logic [NUM_AXES-1:0][COMP_W-1:0]        comp;
    logic [NUM_AXES-1:0][PERIOD_W-1:0]      period;
  } cell_ctrl_t;

  // Search token flags and residues, handed from cell to cell
  typedef struct packed {
    logic                              live;
    logic                              armed;
    logic                              found;
    logic [NUM_AXES-1:0][PERIOD_W-1:0] res;
  } tok_t;

endpackage

[sv/lip_axis_res.sv]
// ----------------------------------------------------------------------------
// lip_axis_res: per-axis residue unit
// Restoring remainder of |component| by the period, one bit per step, then
// the non-negative residue of the component and of its negation.
// ----------------------------------------------------------------------------
module lip_axis_res (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [lip_pkg::COMP_W-1:0]   comp,
  input  logic [lip_pkg::PERIOD_W-1:0] period,
  output logic [lip_pkg::PERIOD_W-1:0] res,
  output logic [lip_pkg::PERIOD_W-1:0] neg_res
);

  localparam int CMW = lip_pkg::COMP_W;
  localparam int PW  = lip_pkg::PERIOD_W;

  logic [CMW-1:0] mag;
  logic [PW-1:0]  rem;
  logic           neg;
  logic [PW:0]    trial;
  logic [PW:0]    trial_sub;

  // Trial subtract for the next quotient bit
  always_comb begin
    trial     = {rem, mag[CMW-1]};
    trial_sub = trial - {1'b0, period};
  end

  // Magnitude shifts out MSB first into the partial remainder
  always_ff @(posedge clk) begin
    if (load) begin
      neg <= comp[CMW-1];
      mag <= comp[CMW-1] ? (~comp + 1'b1) : comp;
      rem <= '0;
    end else if (step) begin
      mag <= {mag[CMW-2:0], 1'b0};
      rem <= (trial >= {1'b0, period}) ? trial_sub[PW-1:0] : trial[PW-1:0];
    end
  end

  // Fold the sign back in; residue of the negation is period - res unless zero
  always_comb begin
    res     = (neg && (rem != '0)) ? period - rem : rem;
    neg_res = (res != '0) ? period - res : '0;
  end

endmodule

[sv/lip_cell.sv]
// ----------------------------------------------------------------------------
// lip_cell: one list entry of the pairing chain
// Holds a vector's residues and its pair record, tests passing search tokens
// and shifts its pair record towards the head when results are read out.
// ----------------------------------------------------------------------------
module lip_cell #(
  parameter int IW  = $clog2(lip_pkg::MAX_VECTORS_DEF),
  parameter int CW  = $clog2(lip_pkg::MAX_VECTORS_DEF + 1),
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lip_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]       load_idx,
  input  logic [CW-1:0]       count,
  input  lip_pkg::tok_t       tok_in,
  input  logic [IW-1:0]       tok_idx_in,
  input  logic [IW-1:0]       tok_part_in,
  output lip_pkg::tok_t       tok_out,
  output logic [IW-1:0]       tok_idx_out,
  output logic [IW-1:0]       tok_part_out,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_idx,
  input  logic [IW-1:0]       wr_part,
  input  logic                nb_valid,
  input  logic [IW-1:0]       nb_idx,
  output logic                pair_valid,
  output logic [IW-1:0]       pair_idx
);

  localparam int NA = lip_pkg::NUM_AXES;
  localparam int PW = lip_pkg::PERIOD_W;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  logic [NA-1:0][PW-1:0] res;
  logic [NA-1:0][PW-1:0] neg_res;
  logic                  load_me;
  logic                  active;
  logic                  own;
  logic                  hit;
  logic                  wr_me;
  lip_pkg::tok_t         tok_next;
  logic [IW-1:0]         part_next;

  assign load_me = ctrl.load && (load_idx == MY_IDX);
  assign wr_me   = wr_en && (wr_idx == MY_IDX);

  // Residue units, one per axis
  for (genvar a = 0; a < NA; a++) begin : g_axis
    lip_axis_res u_axis (
      .clk     (clk),
      .load    (load_me),
      .step    (ctrl.step),
      .comp    (ctrl.comp[a]),
      .period  (ctrl.period[a]),
      .res     (res[a]),
      .neg_res (neg_res[a])
    );
  end

  // Token test: arm at own entry, then match later entries against its residue
  always_comb begin
    active    = MY_POS < count;
    own       = tok_in.live && (tok_idx_in == MY_IDX);
    hit       = (own && !pair_valid && (res == neg_res)) ||
                (tok_in.live && tok_in.armed && !tok_in.found && active &&
                 (tok_in.res == neg_res));
    tok_next  = tok_in;
    part_next = tok_part_in;
    if (own) begin
      tok_next.armed = 1'b1;
      tok_next.res   = res;
      if (pair_valid) begin
        tok_next.live = 1'b0;   // already paired: entry is skipped
      end
    end
    if (hit) begin
      tok_next.found = 1'b1;
      part_next      = MY_IDX;
    end
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_idx_out  <= tok_idx_in;
    tok_part_out <= part_next;
  end

  // Pair record: readout shift, tail write-back, or a match by a passing token
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (ctrl.shift) begin
      pair_valid <= nb_valid;
    end else if (wr_me || hit) begin
      pair_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pair_idx <= nb_idx;
    end else if (wr_me) begin
      pair_idx <= wr_part;
    end else if (hit) begin
      pair_idx <= tok_idx_in;
    end
  end

endmodule

[sv/lattice_inversion_pairing.sv]
// ----------------------------------------------------------------------------
// lattice_inversion_pairing: pairs lattice translations by inversion
// Loading accepts one vector per cycle. After the closing vector, residue
// reduction runs in every cell, then one search token per entry runs down the
// cell chain, then results go out one per cycle as the output register frees.
// Synchronous reset clears the list, the pair records and the output, and sets
// all periods to 1.
// ----------------------------------------------------------------------------
module lattice_inversion_pairing #(
  parameter int MAX_VECTORS = lip_pkg::MAX_VECTORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lip_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output lip_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lip_pkg::PERIOD_W-1:0]  cfg_data
);

  localparam int IW  = $clog2(MAX_VECTORS);
  localparam int CW  = $clog2(MAX_VECTORS + 1);
  localparam int SW  = $clog2(2 * MAX_VECTORS);
  localparam int OW  = lip_pkg::OUT_IDX_W;
  localparam int NA  = lip_pkg::NUM_AXES;
  localparam int PW  = lip_pkg::PERIOD_W;
  localparam int STW = $clog2(lip_pkg::COMP_W);

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_RESID  = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [NA-1:0][PW-1:0] period;
  logic [CW-1:0]         count;
  logic [STW-1:0]        step_cnt;
  logic [SW-1:0]         srch;
  logic [CW-1:0]         out_cnt;

  logic                  item_acc;
  logic                  room;
  logic                  take;
  logic                  last_out;
  logic                  search_end;
  lip_pkg::cell_ctrl_t   ctrl;

  lip_pkg::tok_t         tok      [MAX_VECTORS+1];
  logic [IW-1:0]         tok_idx  [MAX_VECTORS+1];
  logic [IW-1:0]         tok_part [MAX_VECTORS+1];
  logic                  pv       [MAX_VECTORS+1];
  logic [IW-1:0]         pidx     [MAX_VECTORS+1];
  logic                  wr_en;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NA; a++) begin
        period[a] <= lip_pkg::PERIOD_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lip_pkg::REG_PERIOD_X: period[0] <= cfg_data;
        lip_pkg::REG_PERIOD_Y: period[1] <= cfg_data;
        lip_pkg::REG_PERIOD_Z: period[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake terms
  assign item_ready = (state == ST_LOAD);
  assign item_acc   = item_valid && item_ready;
  assign room       = count < CW'(MAX_VECTORS);
  assign take       = (state == ST_OUT) && (!result_valid || result_ready);
  assign last_out   = (out_cnt + CW'(1)) == count;
  assign search_end = srch == (SW'(count) + SW'(MAX_VECTORS - 1));

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (item_acc && item.end_of_list) state_next = ST_RESID;
      end
      ST_RESID: begin
        if (step_cnt == STW'(lip_pkg::COMP_W - 1)) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (search_end) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (take && last_out) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      step_cnt <= '0;
      srch     <= '0;
      out_cnt  <= '0;
    end else begin
      state <= state_next;
      if (item_acc && room) begin
        count <= count + 1'b1;
      end else if (take && last_out) begin
        count <= '0;
      end
      step_cnt <= (state == ST_RESID) ? step_cnt + 1'b1 : '0;
      srch     <= (state == ST_SEARCH) ? srch + 1'b1 : '0;
      if (take) begin
        out_cnt <= last_out ? '0 : out_cnt + 1'b1;
      end
    end
  end

  // Broadcast control; a zero period acts as one
  always_comb begin
    ctrl.load    = item_acc && room;
    ctrl.step    = (state == ST_RESID);
    ctrl.shift   = take;
    ctrl.comp[0] = item.trans_x;
    ctrl.comp[1] = item.trans_y;
    ctrl.comp[2] = item.trans_z;
    for (int a = 0; a < NA; a++) begin
      ctrl.period[a] = (period[a] == '0) ? PW'(1) : period[a];
    end
  end

  // Token injection at the head, one entry per cycle
  always_comb begin
    tok[0].live  = (state == ST_SEARCH) && (srch < SW'(count));
    tok[0].armed = 1'b0;
    tok[0].found = 1'b0;
    tok[0].res   = '0;
    tok_idx[0]   = IW'(srch);
    tok_part[0]  = '0;
  end

  // Tail: write the partner back into the searching entry
  assign wr_en = tok[MAX_VECTORS].live && tok[MAX_VECTORS].found;

  // Nothing shifts in behind the last cell
  assign pv[MAX_VECTORS]   = 1'b0;
  assign pidx[MAX_VECTORS] = '0;

  for (genvar k = 0; k < MAX_VECTORS; k++) begin : g_cell
    lip_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .load_idx     (IW'(count)),
      .count        (count),
      .tok_in       (tok[k]),
      .tok_idx_in   (tok_idx[k]),
      .tok_part_in  (tok_part[k]),
      .tok_out      (tok[k+1]),
      .tok_idx_out  (tok_idx[k+1]),
      .tok_part_out (tok_part[k+1]),
      .wr_en        (wr_en),
      .wr_idx       (tok_idx[MAX_VECTORS]),
      .wr_part      (tok_part[MAX_VECTORS]),
      .nb_valid     (pv[k+1]),
      .nb_idx       (pidx[k+1]),
      .pair_valid   (pv[k]),
      .pair_idx     (pidx[k])
    );
  end

  // Output register, fed from the head cell
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.entry_index   <= OW'(out_cnt);
      result.partner_index <= pv[0] ? OW'(pidx[0]) : '0;
      result.partner_found <= pv[0];
      result.last_result   <= last_out;
    end
  end

endmodule

[sv/lip_checker.sv]
// ----------------------------------------------------------------------------
// lip_checker: port-level checks for lattice inversion pairing
// Result order and stall hold, empty partner encoding, list/readout interlock.
// ----------------------------------------------------------------------------
module lip_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input lip_pkg::item_t                item,
  input logic                          result_valid,
  input logic                          result_ready,
  input lip_pkg::result_t              result
);

  logic [lip_pkg::OUT_IDX_W-1:0] exp_idx;

  // Expected entry index of the next result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (result_valid && result_ready) begin
      exp_idx <= result.last_result ? '0 : exp_idx + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.entry_index == exp_idx)
    else $error("results out of entry order");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.partner_found |-> result.partner_index == '0)
    else $error("partner index set without a partner");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_result |-> !item_ready)
    else $error("input taken during readout");

  a_close: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.end_of_list |=> !item_ready)
    else $error("input taken right after list close");

endmodule

bind lattice_inversion_pairing lip_checker u_lip_checker (.*);

[sim/lattice_inversion_pairing_test.sv]
// ----------------------------------------------------------------------------
// lattice_inversion_pairing_test: self-checking bench for inversion pairing
// Sends lists of lattice translations through the item channel and predicts
// the partner records for each closed list. Results are checked field by field
// in arrival order. Both channels idle at random, and the receiver holds off
// for a long stretch once so that the block backs up.
// ----------------------------------------------------------------------------
module lattice_inversion_pairing_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lip_pkg::*;

  localparam int MAX_V       = MAX_VECTORS_DEF;
  localparam int DRAIN       = 2 * MAX_V + 40;
  localparam int HOLD_CYCLES = 800;
  localparam int TIMEOUT_NS  = 4_000_000;
  // Unused register slot: writes to it must leave every period alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Predicts the partner records of each list and holds them until they arrive
  class pairing_scoreboard;
    int                  cap;
    logic [PERIOD_W-1:0] period [NUM_AXES];
    item_t               held [$];
    result_t             awaited [$];
    int                  errors, checked, lists, stored, dropped;

    function new(int capacity);
      cap = capacity;
      foreach (period[a]) period[a] = PERIOD_RESET;
    endfunction

    function void write_period(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] v);
      case (idx)
        REG_PERIOD_X: period[0] = v;
        REG_PERIOD_Y: period[1] = v;
        REG_PERIOD_Z: period[2] = v;
        default: ;
      endcase
    endfunction

    // Non-negative residue; a zero period behaves as period one
    function int residue_of(int v, int p);
      int m;
      int r;
      m = (p == 0) ? 1 : p;
      r = v % m;
      if (r < 0) r += m;
      return r;
    endfunction

    function int comp(item_t it, int ax);
      case (ax)
        0:       return $signed(it.trans_x);
        1:       return $signed(it.trans_y);
        default: return $signed(it.trans_z);
      endcase
    endfunction

    // True when the negation of b lands on a on every axis
    function bit mirrored(item_t a, item_t b);
      for (int ax = 0; ax < NUM_AXES; ax++)
        if (residue_of(comp(a, ax), int'(period[ax])) !=
            residue_of(-comp(b, ax), int'(period[ax])))
          return 1'b0;
      return 1'b1;
    endfunction

    function void note_item(item_t it);
      int      n;
      int      partner [];
      bit      paired [];
      result_t r;
      if (held.size() < cap) begin
        held.push_back(it);
        stored++;
      end else begin
        dropped++;
      end
      if (!it.end_of_list) return;
      n = held.size();
      partner = new[n];
      paired = new[n];
      // First-fit search; a later match may overwrite an earlier record
      for (int i = 0; i < n; i++) begin
        if (paired[i]) continue;
        for (int j = i; j < n; j++) begin
          if (mirrored(held[i], held[j])) begin
            partner[i] = j;
            paired[i] = 1'b1;
            if (j != i) begin
              partner[j] = i;
              paired[j] = 1'b1;
            end
            break;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        r.entry_index   = OUT_IDX_W'(i);
        r.partner_index = paired[i] ? OUT_IDX_W'(partner[i]) : '0;
        r.partner_found = paired[i];
        r.last_result   = (i == n - 1);
        awaited.push_back(r);
      end
      held.delete();
      lists++;
    endfunction

    function void compare(string field, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare("entry_index", want.entry_index, got.entry_index);
      compare("partner_index", want.partner_index, got.partner_index);
      compare("partner_found", want.partner_found, got.partner_found);
      compare("last_result", want.last_result, got.last_result);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  item_t                item         = '0;
  logic                 result_ready = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [PERIOD_W-1:0]  cfg_data     = '0;
  logic                 item_ready, result_valid, cfg_ready;
  result_t              result;

  pairing_scoreboard sb = new(MAX_V);

  int burst_left    = 0;
  int settings      = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int pattern_left  = 0;
  logic [15:0] stall_pattern = '1;

  lattice_inversion_pairing #(.MAX_VECTORS(MAX_V)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: long hold-off on request, otherwise a rotating stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
        if (stall_pattern == '0) stall_pattern[0] = 1'b1;
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      result_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // Offer one vector; bursts of random length with random gaps between them
  task automatic drive_item(input item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    forever begin
      @(posedge clk);
      if (item_ready) break;
    end
    sb.note_item(it);
  endtask

  task automatic send_vec(input int x, input int y, input int z, input bit last);
    item_t it;
    it.trans_x     = 8'(x);
    it.trans_y     = 8'(y);
    it.trans_z     = 8'(z);
    it.end_of_list = last;
    drive_item(it);
  endtask

  // Stop offering, let every result arrive, then let the block settle
  task automatic quiesce();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_period(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_periods(input int px, input int py, input int pz);
    quiesce();
    write_reg(REG_PERIOD_X, 8'(px));
    write_reg(REG_PERIOD_Y, 8'(py));
    write_reg(REG_PERIOD_Z, 8'(pz));
    settings++;
  endtask

  // A component whose negation matches v under period p, shifted by whole periods
  function automatic int mirror_comp(int v, int p);
    int pe;
    int w;
    pe = (p == 0) ? 1 : p;
    w = -v;
    while (w > 127) w -= pe;
    repeat ($urandom_range(0, 3)) begin
      if (w + pe <= 127 && $urandom_range(0, 1) == 1) w += pe;
      else if (w - pe >= -128) w -= pe;
    end
    return w;
  endfunction

  // One list; shaped lists mostly hold mirror images of earlier entries
  task automatic random_list(input int len, input bit shaped);
    item_t pool [$];
    item_t it;
    int    src;
    for (int k = 0; k < len; k++) begin
      if (shaped && k > 0 && $urandom_range(0, 2) != 0) begin
        src = $urandom_range(0, pool.size() - 1);
        it.trans_x = 8'(mirror_comp($signed(pool[src].trans_x), int'(sb.period[0])));
        it.trans_y = 8'(mirror_comp($signed(pool[src].trans_y), int'(sb.period[1])));
        it.trans_z = 8'(mirror_comp($signed(pool[src].trans_z), int'(sb.period[2])));
      end else begin
        it.trans_x = 8'($urandom_range(0, 255));
        it.trans_y = 8'($urandom_range(0, 255));
        it.trans_z = 8'($urandom_range(0, 255));
      end
      it.end_of_list = (k == len - 1);
      pool.push_back(it);
      drive_item(it);
    end
  endtask

  function automatic int pick_period(int mode);
    case (mode)
      0, 1, 2: return $urandom_range(1, 8);
      3: begin
        case ($urandom_range(0, 3))
          0:       return 0;
          1:       return 1;
          2:       return 128;
          default: return 255;
        endcase
      end
      4:       return $urandom_range(0, 255);
      default: return $urandom_range(1, 32);
    endcase
  endfunction

  // Stimulus
  initial begin
    int target;
    int phase;
    int mode;
    int len;
    int big_lists;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset periods of one: any vector pairs with itself
    send_vec(127, -128, 0, 1'b1);

    // Period four: a record overwritten by a later match, then an entry alone
    set_periods(4, 4, 4);
    send_vec(1, 0, 0, 1'b0);
    send_vec(1, 0, 0, 1'b0);
    send_vec(3, 0, 0, 1'b1);
    send_vec(1, 0, 0, 1'b1);
    send_vec(2, -2, 0, 1'b0);
    send_vec(0, 0, 1, 1'b1);

    // Zero periods act as period one
    set_periods(0, 0, 0);
    send_vec(5, -7, 100, 1'b0);
    send_vec(-128, 127, 1, 1'b1);

    // Period 128: the most negative component is its own inverse
    set_periods(128, 128, 128);
    send_vec(-128, 64, 0, 1'b0);
    send_vec(127, -127, 1, 1'b0);
    send_vec(1, -1, -1, 1'b1);

    // Periods above 128 are used as written
    set_periods(255, 255, 255);
    send_vec(-128, -128, -128, 1'b0);
    send_vec(127, 127, 127, 1'b0);
    send_vec(-127, -127, -127, 1'b1);

    // Write to the spare slot, then mixed periods
    quiesce();
    write_reg(CFG_SPARE, 8'd7);
    set_periods(1, 128, 0);
    send_vec(0, 0, 0, 1'b0);
    send_vec(-1, 1, -1, 1'b1);

    // Random phases: new periods, then several lists
    target = sb.stored + 200;
    phase = 0;
    big_lists = 0;
    while (sb.stored < target) begin
      mode = $urandom_range(0, 5);
      set_periods(pick_period(mode), pick_period(mode), pick_period(mode));
      if (phase == 1) hold_requests++;
      repeat ($urandom_range(3, 6)) begin
        if (phase == 2 && big_lists == 0) begin
          len = MAX_V + $urandom_range(1, 6);
          big_lists++;
        end else if (big_lists < 3 && $urandom_range(0, 15) == 0) begin
          len = MAX_V;
          big_lists++;
        end else begin
          len = $urandom_range(1, 12);
        end
        random_list(len, $urandom_range(0, 4) != 0);
      end
      phase++;
    end

    quiesce();
    $display("Covered %0d lists, %0d vectors held, %0d dropped past capacity, %0d period sets",
             sb.lists, sb.stored, sb.dropped, settings);
    $display("Checked %0d partner results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
sv/lip_pkg.sv
sv/lip_axis_res.sv
sv/lip_cell.sv
sv/lattice_inversion_pairing.sv
sv/lip_checker.sv
sim/lattice_inversion_pairing_test.sv
